### design/mwsm_pkg.sv
// Shared constants, tables and types for the mecanum wheel speed mixer.
package mwsm_pkg;

    localparam int ANGLE_W      = 32;
    localparam int HEADING_W    = 16;
    localparam int GUARD        = 8;
    localparam int GAIN_SHIFT   = 20;
    localparam int GAIN_W       = 21;
    localparam int INV_GAIN     = 636751;
    localparam int ATAN_ENTRIES = 24;
    localparam int CFG_INDEX_W  = 4;

    localparam logic [ANGLE_W-1:0] HALF_TURN   = 32'h8000_0000;
    localparam logic [ANGLE_W-1:0] EIGHTH_TURN = 32'h2000_0000;
    localparam logic [ANGLE_W-1:0] HEAD_ROUND  = 32'h0000_8000;

    // Arctangent of 2^-i as a fraction of a full turn, 2^32 per turn.
    localparam logic [ANGLE_W-1:0] ATAN_TURN [ATAN_ENTRIES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;
    typedef logic [ANGLE_W-1:0]     t_angle;
    typedef logic [HEADING_W-1:0]   t_heading;

    localparam t_cfg_index REG_MIN_SPEED = 4'd0;
    localparam t_cfg_index REG_MAX_SPEED = 4'd1;

endpackage

### design/mecanum_wheel_speed_mixer_unit.sv
// Mecanum wheel speed mixer: joystick vector to heading, magnitude and four wheel speeds.
// Throughput is one beat per cycle: every stage is a register slice, so busy never rises.
// The rate is set by the unrolled CORDIC pipelines, one stage per iteration.
// The receiver cannot stall; each result is on the outputs for exactly one cycle.
// Synchronous active-low reset clears all valid bits and sets the clamps to
// +/-(2^(SAMPLE_WIDTH-1)-1).
module mecanum_wheel_speed_mixer_unit #(
    parameter int CORDIC_STAGES = 16,
    parameter int SAMPLE_WIDTH  = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Command channel: a beat is taken when start is high and busy is low.
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic signed [SAMPLE_WIDTH-1:0] i_stick_y,
    input  logic signed [SAMPLE_WIDTH-1:0] i_stick_x,
    // Configuration write channel.
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  mwsm_pkg::t_cfg_index           i_cfg_index,
    input  logic [SAMPLE_WIDTH-1:0]        i_cfg_data,
    // Result strobe and payload.
    output logic                           o_done,
    output mwsm_pkg::t_heading             o_heading,
    output logic signed [SAMPLE_WIDTH-1:0] o_speed_magnitude,
    output logic signed [SAMPLE_WIDTH-1:0] o_front_left_speed,
    output logic signed [SAMPLE_WIDTH-1:0] o_front_right_speed,
    output logic signed [SAMPLE_WIDTH-1:0] o_back_left_speed,
    output logic signed [SAMPLE_WIDTH-1:0] o_back_right_speed
);
    import mwsm_pkg::*;

    localparam int SW = SAMPLE_WIDTH;
    // CORDIC datapath width: guard bits plus headroom for the gain and the sqrt(2) of a
    // diagonal vector.
    localparam int W  = SW + GUARD + 3;
    // Width after gain removal.
    localparam int DW = W + GAIN_W - GAIN_SHIFT - GUARD;
    // Cycles from the mix stage to the rotation results leaving gain removal.
    localparam int ROT_LAT = CORDIC_STAGES + 3;

    localparam logic signed [SW-1:0] MIN_RESET = -((SW'(1) <<< (SW - 1)) - SW'(1));
    localparam logic signed [SW-1:0] MAX_RESET = (SW'(1) <<< (SW - 1)) - SW'(1);

    // Clamp order matters when the limits cross: below min wins first.
    function automatic logic signed [SW-1:0] f_clamp(
        input logic signed [DW-1:0] v,
        input logic signed [SW-1:0] lo,
        input logic signed [SW-1:0] hi
    );
        logic signed [SW-1:0] res;
        if (v < DW'(lo)) begin
            res = lo;
        end else if (v > DW'(hi)) begin
            res = hi;
        end else begin
            res = v[SW-1:0];
        end
        return res;
    endfunction

    // ---------------------------------------------------------------------
    // Configuration registers; unknown indexes are dropped. Writes must arrive only
    // while the pipeline is empty (not enforced), so every stage may read them directly.
    // ---------------------------------------------------------------------
    logic signed [SW-1:0] r_min_speed;
    logic signed [SW-1:0] r_max_speed;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_speed <= MIN_RESET;
            r_max_speed <= MAX_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_MIN_SPEED: r_min_speed <= signed'(i_cfg_data);
                REG_MAX_SPEED: r_max_speed <= signed'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Vectoring CORDIC: angle and scaled length of the stick vector.
    // ---------------------------------------------------------------------
    logic                vec_valid;
    logic                vec_zero;
    logic signed [W-1:0] vec_x;
    t_angle              vec_ang;

    mwsm_vector #(
        .SW     (SW),
        .STAGES (CORDIC_STAGES),
        .W      (W)
    ) u_vector (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_start && !o_busy),
        .i_y     (i_stick_y),
        .i_x     (i_stick_x),
        .o_valid (vec_valid),
        .o_zero  (vec_zero),
        .o_x     (vec_x),
        .o_ang   (vec_ang)
    );

    // A zero stick has heading zero and length zero; force both here.
    logic                 mag_valid;
    logic signed [DW-1:0] mag_raw;
    t_angle               r_ang_d1;
    t_angle               r_ang_d2;

    mwsm_descale #(
        .IN_W (W)
    ) u_mag_descale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (vec_valid),
        .i_v     (vec_zero ? '0 : vec_x),
        .o_valid (mag_valid),
        .o_v     (mag_raw)
    );

    always_ff @(posedge i_clk) begin
        r_ang_d1 <= vec_zero ? '0 : vec_ang;
        r_ang_d2 <= r_ang_d1;
    end

    // ---------------------------------------------------------------------
    // Mix stage: round the angle to a 16-bit heading and clamp the length.
    // ---------------------------------------------------------------------
    t_angle               ang_rounded;
    logic                 r_mix_valid;
    t_heading             r_mix_head;
    logic signed [SW-1:0] r_mix_mag;

    assign ang_rounded = r_ang_d2 + HEAD_ROUND;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mix_valid <= 1'b0;
        end else begin
            r_mix_valid <= mag_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mix_head <= ang_rounded[ANGLE_W-1:ANGLE_W-HEADING_W];
        r_mix_mag  <= f_clamp(mag_raw, r_min_speed, r_max_speed);
    end

    // ---------------------------------------------------------------------
    // Two rotation lanes: left wheels at heading + pi/4, right at heading - pi/4.
    // ---------------------------------------------------------------------
    t_angle head_turn;
    assign head_turn = {r_mix_head, {(ANGLE_W - HEADING_W){1'b0}}};

    logic                 left_rot_valid;
    logic                 right_rot_valid;
    logic signed [W-1:0]  left_rot_y;
    logic signed [W-1:0]  right_rot_y;
    logic                 left_valid;
    logic                 right_valid;
    logic signed [DW-1:0] left_raw;
    logic signed [DW-1:0] right_raw;

    mwsm_rotate #(
        .SW     (SW),
        .STAGES (CORDIC_STAGES),
        .W      (W)
    ) u_rotate_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_mix_valid),
        .i_ang   (head_turn + EIGHTH_TURN),
        .i_m     (r_mix_mag),
        .o_valid (left_rot_valid),
        .o_y     (left_rot_y)
    );

    mwsm_rotate #(
        .SW     (SW),
        .STAGES (CORDIC_STAGES),
        .W      (W)
    ) u_rotate_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_mix_valid),
        .i_ang   (head_turn - EIGHTH_TURN),
        .i_m     (r_mix_mag),
        .o_valid (right_rot_valid),
        .o_y     (right_rot_y)
    );

    mwsm_descale #(
        .IN_W (W)
    ) u_left_descale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (left_rot_valid),
        .i_v     (left_rot_y),
        .o_valid (left_valid),
        .o_v     (left_raw)
    );

    mwsm_descale #(
        .IN_W (W)
    ) u_right_descale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (right_rot_valid),
        .i_v     (right_rot_y),
        .o_valid (right_valid),
        .o_v     (right_raw)
    );

    // Heading and magnitude ride a delay line alongside the rotation lanes.
    t_heading             r_head_dl [ROT_LAT];
    logic signed [SW-1:0] r_mag_dl  [ROT_LAT];

    always_ff @(posedge i_clk) begin
        r_head_dl[0] <= r_mix_head;
        r_mag_dl[0]  <= r_mix_mag;
    end

    for (genvar k = 1; k < ROT_LAT; k++) begin : g_delay
        always_ff @(posedge i_clk) begin
            r_head_dl[k] <= r_head_dl[k-1];
            r_mag_dl[k]  <= r_mag_dl[k-1];
        end
    end

    // ---------------------------------------------------------------------
    // Output register: final clamps and the one-cycle done strobe. Both lanes
    // run in lockstep, so their valid bits always agree.
    // ---------------------------------------------------------------------
    logic                 r_done;
    t_heading             r_heading;
    logic signed [SW-1:0] r_magnitude;
    logic signed [SW-1:0] r_left_speed;
    logic signed [SW-1:0] r_right_speed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= left_valid && right_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_heading     <= r_head_dl[ROT_LAT-1];
        r_magnitude   <= r_mag_dl[ROT_LAT-1];
        r_left_speed  <= f_clamp(left_raw, r_min_speed, r_max_speed);
        r_right_speed <= f_clamp(right_raw, r_min_speed, r_max_speed);
    end

    assign o_done              = r_done;
    assign o_heading           = r_heading;
    assign o_speed_magnitude   = r_magnitude;
    assign o_front_left_speed  = r_left_speed;
    assign o_front_right_speed = r_right_speed;
    assign o_back_left_speed   = r_left_speed;
    assign o_back_right_speed  = r_right_speed;

endmodule

### design/mwsm_vector.sv
// Pipelined vectoring CORDIC: vector length (with gain) and angle of (y, x).
module mwsm_vector #(
    parameter int SW     = 16,
    parameter int STAGES = 16,
    parameter int W      = 27
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic signed [SW-1:0]  i_y,
    input  logic signed [SW-1:0]  i_x,
    output logic                  o_valid,
    output logic                  o_zero,
    output logic signed [W-1:0]   o_x,
    output mwsm_pkg::t_angle      o_ang
);
    import mwsm_pkg::*;

    logic                r_vld  [STAGES+1];
    logic                r_zero [STAGES+1];
    logic signed [W-1:0] r_x    [STAGES+1];
    logic signed [W-1:0] r_y    [STAGES+1];
    t_angle              r_ang  [STAGES+1];

    logic signed [W-1:0] n_x0;
    logic signed [W-1:0] n_y0;

    // Vectors in the left half plane are turned by half a turn first.
    always_comb begin
        n_x0 = W'(i_x) <<< GUARD;
        n_y0 = W'(i_y) <<< GUARD;
        if (i_x < 0) begin
            n_x0 = -n_x0;
            n_y0 = -n_y0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0]    <= n_x0;
        r_y[0]    <= n_y0;
        r_ang[0]  <= (i_x < 0) ? HALF_TURN : '0;
        r_zero[0] <= (i_x == '0) && (i_y == '0);
    end

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        localparam t_angle ATAN_K = ATAN_TURN[k];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_zero[k+1] <= r_zero[k];
            if (r_y[k] > 0) begin
                r_x[k+1]   <= r_x[k] + (r_y[k] >>> k);
                r_y[k+1]   <= r_y[k] - (r_x[k] >>> k);
                r_ang[k+1] <= r_ang[k] + ATAN_K;
            end else begin
                r_x[k+1]   <= r_x[k] - (r_y[k] >>> k);
                r_y[k+1]   <= r_y[k] + (r_x[k] >>> k);
                r_ang[k+1] <= r_ang[k] - ATAN_K;
            end
        end
    end

    assign o_valid = r_vld[STAGES];
    assign o_zero  = r_zero[STAGES];
    assign o_x     = r_x[STAGES];
    assign o_ang   = r_ang[STAGES];

endmodule

### design/mwsm_rotate.sv
// Pipelined rotation CORDIC: m * sin(angle) with the CORDIC gain still applied.
module mwsm_rotate #(
    parameter int SW     = 16,
    parameter int STAGES = 16,
    parameter int W      = 27
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  mwsm_pkg::t_angle      i_ang,
    input  logic signed [SW-1:0]  i_m,
    output logic                  o_valid,
    output logic signed [W-1:0]   o_y
);
    import mwsm_pkg::*;

    localparam int ZW = ANGLE_W + 1;

    logic                 r_vld [STAGES+1];
    logic signed [W-1:0]  r_x   [STAGES+1];
    logic signed [W-1:0]  r_y   [STAGES+1];
    logic signed [ZW-1:0] r_z   [STAGES+1];

    logic signed [W-1:0] n_x0;
    t_angle              n_a0;

    // Angles in the second and third quadrant are folded by half a turn.
    always_comb begin
        n_x0 = W'(i_m) <<< GUARD;
        n_a0 = i_ang;
        if (i_ang[ANGLE_W-1] != i_ang[ANGLE_W-2]) begin
            n_a0 = i_ang ^ HALF_TURN;
            n_x0 = -n_x0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0] <= n_x0;
        r_y[0] <= '0;
        r_z[0] <= signed'({n_a0[ANGLE_W-1], n_a0});
    end

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        localparam logic signed [ZW-1:0] ATAN_K = ZW'(ATAN_TURN[k]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (r_z[k] >= 0) begin
                r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                r_z[k+1] <= r_z[k] - ATAN_K;
            end else begin
                r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                r_z[k+1] <= r_z[k] + ATAN_K;
            end
        end
    end

    assign o_valid = r_vld[STAGES];
    assign o_y     = r_y[STAGES];

endmodule

### design/mwsm_descale.sv
// Two-stage gain removal: multiply by the inverse CORDIC gain, then round and drop guard bits.
module mwsm_descale #(
    parameter int IN_W = 27
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    input  logic signed [IN_W-1:0]                   i_v,
    output logic                                     o_valid,
    output logic signed [IN_W+mwsm_pkg::GAIN_W-mwsm_pkg::GAIN_SHIFT-mwsm_pkg::GUARD-1:0] o_v
);
    import mwsm_pkg::*;

    localparam int PW    = IN_W + GAIN_W;
    localparam int SHIFT = GAIN_SHIFT + GUARD;
    localparam logic signed [PW-1:0] GAIN  = PW'(INV_GAIN);
    localparam logic signed [PW-1:0] ROUND = PW'(1) <<< (SHIFT - 1);

    logic                 r_vld1;
    logic                 r_vld2;
    logic signed [PW-1:0] r_prod;
    logic signed [PW-1:0] n_sum;
    logic signed [PW-SHIFT-1:0] r_res;

    assign n_sum = r_prod + ROUND;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
        end
    end

    // Taking the upper bits of a signed sum floors, so this rounds half up.
    always_ff @(posedge i_clk) begin
        r_prod <= PW'(i_v) * GAIN;
        r_res  <= n_sum[PW-1:SHIFT];
    end

    assign o_valid = r_vld2;
    assign o_v     = r_res;

endmodule
